>>> design/iocr_pkg.sv
package iocr_pkg;

   // Number of held entries in the reorder window (2 to 64).
   localparam int WINDOW_DEPTH = 32;
   // Number of command bits that are kept and released (8 to 64).
   localparam int COMMAND_WIDTH = 64;

   localparam int SLOT_W = 32;
   localparam int CMD_FIELD_W = 64;
   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int DIST_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = DIST_W + 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   localparam logic [1:0] STATUS_EXECUTED = 2'd0;
   localparam logic [1:0] STATUS_STALE    = 2'd1;
   localparam logic [1:0] STATUS_BEYOND   = 2'd2;

   typedef struct packed {
      logic [SLOT_W-1:0]      slot_number;
      logic [CMD_FIELD_W-1:0] command_word;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]      released_slot;
      logic [CMD_FIELD_W-1:0] released_command;
      logic [1:0]             status_code;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic decide;
      logic drain;
   } ctrl_cmd_type;

   typedef struct packed {
      logic more;
   } dp_status_type;

   // Advance a window index by step (step <= WINDOW_DEPTH), wrapping once.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [DIST_W-1:0] step);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(idx) + SUM_W'(step);
      if (sum >= SUM_W'(WINDOW_DEPTH)) begin
         sum = sum - SUM_W'(WINDOW_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> design/iocr_ctrl.sv
module iocr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  iocr_pkg::dp_status_type status,
   output iocr_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECIDE = 3'b010,
      ST_DRAIN  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = status.more ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            state_in = status.more ? ST_DRAIN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/iocr_datapath.sv
module iocr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  iocr_pkg::ctrl_cmd_type  cmd,
   input  iocr_pkg::req_type       req_payload,
   output iocr_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output iocr_pkg::rsp_type       rsp_payload
);

   localparam int WD = iocr_pkg::WINDOW_DEPTH;
   localparam int CW = iocr_pkg::COMMAND_WIDTH;
   localparam int SW = iocr_pkg::SLOT_W;
   localparam int FW = iocr_pkg::CMD_FIELD_W;
   localparam int IW = iocr_pkg::IDX_W;
   localparam int DW = iocr_pkg::DIST_W;
   localparam int NW = iocr_pkg::CNT_W;

   iocr_pkg::req_type req_ff;
   iocr_pkg::rsp_type out_ff, out_in;
   logic              out_vld_ff, out_vld_in;
   logic [SW-1:0]     exec_ff, exec_in;
   logic [IW-1:0]     exec_idx_ff, exec_idx_in;
   logic [SW-1:0]     hc_ff, hc_in;
   logic [WD-1:0]     valid_ff, valid_in;
   logic [NW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_ff;
   logic [CW-1:0]     mem [WD];

   logic [SW-1:0] slot, span, hc_max, succ_slot;
   logic [CW-1:0] cmd_kept;
   logic          stale, beyond, is_next, hold;
   logic [IW-1:0] hold_idx, next1, next2;
   logic [NW-1:0] count_nx;
   logic          more_dec, more_drn;

   always_comb begin
      slot     = req_ff.slot_number;
      cmd_kept = req_ff.command_word[CW-1:0];
      stale    = (slot <= exec_ff);
      span     = slot - exec_ff;
      beyond   = !stale && (span > SW'(WD));
      is_next  = !stale && !beyond && (span == SW'(1));
      hold     = !stale && !beyond && !is_next;
      hold_idx = iocr_pkg::wrap_add(exec_idx_ff, span[DW-1:0]);
      next1    = iocr_pkg::wrap_add(exec_idx_ff, DW'(1));
      next2    = iocr_pkg::wrap_add(exec_idx_ff, DW'(2));
      hc_max   = (slot > hc_ff) ? slot : hc_ff;
      // The entry after the released slot decides whether the run goes on.
      more_dec  = (slot < hc_max) && valid_ff[next2];
      succ_slot = exec_ff + SW'(1);
      count_nx  = count_ff + NW'(1);
      more_drn  = (succ_slot < hc_ff) && valid_ff[next2] && (count_nx < NW'(WD));
   end

   assign status.more = cmd.decide ? (is_next && more_dec) : more_drn;

   always_comb begin
      exec_in     = exec_ff;
      exec_idx_in = exec_idx_ff;
      hc_in       = hc_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      out_vld_in  = 1'b0;
      out_in      = out_ff;
      if (cmd.decide) begin
         out_vld_in                = !hold;
         out_in.released_slot      = slot;
         out_in.released_command   = '0;
         out_in.last_of_run        = 1'b1;
         out_in.status_code        = stale ? iocr_pkg::STATUS_STALE :
                                     iocr_pkg::STATUS_BEYOND;
         if (!stale && !beyond) begin
            hc_in = hc_max;
         end
         if (hold) begin
            valid_in[hold_idx] = 1'b1;
         end
         if (is_next) begin
            out_in.released_command = FW'(cmd_kept);
            out_in.status_code      = iocr_pkg::STATUS_EXECUTED;
            out_in.last_of_run      = !more_dec;
            valid_in[next1]         = 1'b0;
            exec_in                 = slot;
            exec_idx_in             = next1;
            count_in                = NW'(1);
         end
      end else if (cmd.drain) begin
         out_vld_in              = 1'b1;
         out_in.released_slot    = succ_slot;
         out_in.released_command = FW'(rd_ff);
         out_in.status_code      = iocr_pkg::STATUS_EXECUTED;
         out_in.last_of_run      = !more_drn;
         valid_in[next1]         = 1'b0;
         exec_in                 = succ_slot;
         exec_idx_in             = next1;
         count_in                = count_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff     <= '0;
         exec_idx_ff <= '0;
         hc_ff       <= '0;
         valid_ff    <= '0;
         count_ff    <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         exec_ff     <= exec_in;
         exec_idx_ff <= exec_idx_in;
         hc_ff       <= hc_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      out_ff <= out_in;
   end

   // Held commands; the read always targets the entry two past the last release.
   always_ff @(posedge clock) begin
      if (cmd.decide && hold) begin
         mem[hold_idx] <= cmd_kept;
      end
      rd_ff <= mem[next2];
   end

   assign rsp_strobe  = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

>>> design/in_order_commit_release.sv
// Channel   Ports                              Beat taken when
// request   start, busy, req_payload           start high and busy low at a clock edge
// response  rsp_strobe, rsp_payload            rsp_strobe high at a clock edge
//
// A notice is handled in steps: the beat is captured, then it is classified and
// its first result, if any, is loaded into the output register.
// A release that finds buffered successors then drains them, one per drain step;
// the drain walks the held-command memory at one read per cycle, so a notice
// gives n results (n from 1 to WINDOW_DEPTH), and a held notice gives no
// result but still passes through capture and classification.
// Reset is synchronous and active high; it empties the window and restarts at slot 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
module in_order_commit_release (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iocr_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output iocr_pkg::rsp_type rsp_payload
);

   iocr_pkg::ctrl_cmd_type  cmd;
   iocr_pkg::dp_status_type status;

   // The controller sequences capture, classification and the drain run.
   iocr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the slot counters, the valid bits and the command memory.
   iocr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // A result is produced only by work started in a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without preceding work");

   // Error results stand alone and carry no command.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status_code != iocr_pkg::STATUS_EXECUTED)
         |-> (rsp_payload.last_of_run && rsp_payload.released_command == '0))
      else $error("error result not terminal or carries a command");

   // A run that is not marked finished continues in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.last_of_run) |=>
         (rsp_strobe && rsp_payload.released_slot == $past(rsp_payload.released_slot) + 32'd1))
      else $error("drain run broken");

   // An accepted beat always makes the block busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat not processed");

endmodule
